// ===== hw/rtl/ism_pkg.sv =====
// shared types and constants for the interval set merge table
package ism_pkg;

  localparam int MAX_SPANS_DEF = 16;
  localparam int UID_W         = 32;
  localparam int ACT_W         = 2;
  localparam int ST_W          = 2;
  localparam int USED_W        = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD        = 2'd0,
    ACT_CONTAINS   = 2'd1,
    ACT_NEXT_LOWER = 2'd2
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_BUSY = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_RB_READ,
    S_RB_EVAL,
    S_RB_EMIT,
    S_RB_TAIL,
    S_RB_FLUSH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic touch;
    logic covered;
    logic after;
    logic first_lt_lo;
    logic last_gt_hi;
    logic lo_in_span;
    logic below;
  } cmp_res_t;

endpackage

// ===== hw/rtl/ism_channels.sv =====
// request and response channel interfaces

interface ism_req_if;
  import ism_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [UID_W-1:0] uid_value;
  logic [UID_W-1:0] span_length;
  modport source(output valid, action, uid_value, span_length, input ready);
  modport sink(input valid, action, uid_value, span_length, output ready);
endinterface

interface ism_rsp_if;
  import ism_pkg::*;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [UID_W-1:0]  found_uid;
  logic [USED_W-1:0] entries_used;
  modport source(output valid, status, found_uid, entries_used, input ready);
  modport sink(input valid, status, found_uid, entries_used, output ready);
endinterface

// ===== hw/rtl/ism_mem.sv =====
// interval storage: one write port, one registered read port
module ism_mem #(
  parameter int DEPTH = ism_pkg::MAX_SPANS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [ism_pkg::UID_W-1:0] wfirst,
  input  logic [ism_pkg::UID_W-1:0] wlast,
  input  logic [AW-1:0]           raddr,
  output logic [ism_pkg::UID_W-1:0] rfirst,
  output logic [ism_pkg::UID_W-1:0] rlast
);
  import ism_pkg::*;

  logic [UID_W-1:0] mem_first [DEPTH];
  logic [UID_W-1:0] mem_last  [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_first[waddr] <= wfirst;
      mem_last[waddr]  <= wlast;
    end
  end

  always_ff @(posedge clk) begin
    rfirst <= mem_first[raddr];
    rlast  <= mem_last[raddr];
  end

endmodule

// ===== hw/rtl/ism_cmp.sv =====
// shared compare unit: one stored interval against the working bounds
module ism_cmp (
  input  logic [ism_pkg::UID_W-1:0] ent_first,
  input  logic [ism_pkg::UID_W-1:0] ent_last,
  input  logic [ism_pkg::UID_W-1:0] lo,
  input  logic [ism_pkg::UID_W-1:0] hi,
  output ism_pkg::cmp_res_t         res
);
  import ism_pkg::*;

  logic [UID_W:0] hi_inc;
  logic [UID_W:0] last_inc;

  assign hi_inc   = {1'b0, hi} + {{UID_W{1'b0}}, 1'b1};
  assign last_inc = {1'b0, ent_last} + {{UID_W{1'b0}}, 1'b1};

  always_comb begin
    res.touch       = ({1'b0, ent_first} <= hi_inc) && (last_inc >= {1'b0, lo});
    res.covered     = (ent_first >= lo) && (ent_last <= hi);
    res.after       = ent_first > lo;
    res.first_lt_lo = ent_first < lo;
    res.last_gt_hi  = ent_last > hi;
    res.lo_in_span  = (ent_first <= lo) && (lo <= ent_last);
    res.below       = ent_last < lo;
  end

endmodule

// ===== hw/rtl/interval_set_merge_table.sv =====
// interval set merge table: sequencer, working registers and result stage
//
//   channel  dir  payload                                  transaction when
//   req      in   action, uid_value, span_length           req.valid && req.ready
//   rsp      out  status, found_uid, entries_used          rsp.valid && rsp.ready
//
// a query scans each held interval once; an add scans them and may then rebuild
// the table; the next transaction is taken once the result is in the output register;
// the single memory read port and the shared compare unit make these steps sequential.
// reset clears the count and control; interval memory is not cleared.
// a finished result waits in the output register while the next transaction is taken;
// a later result waits in its last step until the output register is free.
module interval_set_merge_table #(
  parameter int MAX_SPANS = ism_pkg::MAX_SPANS_DEF
) (
  input logic clk,
  input logic rst,
  ism_req_if.sink   req,
  ism_rsp_if.source rsp
);
  import ism_pkg::*;

  localparam int IDX_W = $clog2(MAX_SPANS);
  localparam int CNT_W = $clog2(MAX_SPANS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SPANS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  state_t state, state_next;

  logic [ACT_W-1:0] act, act_next;
  logic [UID_W-1:0] lo, lo_next, hi, hi_next;
  logic [UID_W-1:0] best, best_next;
  logic             touched, touched_next, hit, hit_next, have, have_next;
  logic             pend, pend_next, placed, placed_next, bvalid, bvalid_next;
  logic [UID_W-1:0] bfirst, bfirst_next, blast, blast_next;
  logic [CNT_W-1:0] idx, idx_next, wk, wk_next, total, total_next;
  logic [ST_W-1:0]  fin_status, fin_status_next;
  logic [UID_W-1:0] fin_found, fin_found_next;

  logic              out_valid, out_valid_next;
  logic [ST_W-1:0]   out_status;
  logic [UID_W-1:0]  out_found;
  logic [USED_W-1:0] out_used;
  logic              out_load;
  logic [31:0]       total_ext;

  logic [IDX_W-1:0] raddr, waddr;
  logic             mem_we;
  logic [UID_W-1:0] rfirst, rlast, wfirst, wlast;

  logic             emit_en;
  logic [UID_W-1:0] emit_first, emit_last;
  logic [CNT_W-1:0] idx_inc;
  logic [UID_W:0]   add_end;
  logic [UID_W-1:0] add_hi;
  cmp_res_t         cmp;

  ism_mem #(.DEPTH(MAX_SPANS), .AW(IDX_W)) u_mem (
    .clk(clk), .we(mem_we), .waddr(waddr), .wfirst(wfirst), .wlast(wlast),
    .raddr(raddr), .rfirst(rfirst), .rlast(rlast)
  );

  ism_cmp u_cmp (
    .ent_first(rfirst), .ent_last(rlast), .lo(lo), .hi(hi), .res(cmp)
  );

  assign idx_inc   = idx + CNT_ONE;
  assign add_end   = {1'b0, req.uid_value} + {1'b0, req.span_length}
                     - {{UID_W{1'b0}}, 1'b1};
  assign add_hi    = add_end[UID_W] ? {UID_W{1'b1}} : add_end[UID_W-1:0];
  assign out_load  = (state == S_DONE) && (!out_valid || rsp.ready);
  assign total_ext = 32'(total);

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.found_uid    = out_found;
  assign rsp.entries_used = out_used;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.action == ACT_ADD) begin
            state_next = (req.span_length == '0) ? S_DONE : S_SCAN;
          end else if (req.action == ACT_CONTAINS) begin
            state_next = S_SCAN;
          end else if (req.action == ACT_NEXT_LOWER) begin
            state_next = (req.uid_value == '0) ? S_DONE : S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (!pend && !(idx < total)) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (act != ACT_ADD) begin
          state_next = S_DONE;
        end else if (!touched && (total >= CNT_MAX)) begin
          state_next = S_DONE;
        end else if (total == '0) begin
          state_next = S_RB_TAIL;
        end else begin
          state_next = S_RB_READ;
        end
      end
      S_RB_READ: state_next = S_RB_EVAL;
      S_RB_EVAL: begin
        if (!cmp.covered && !placed && cmp.after) begin
          state_next = S_RB_EMIT;
        end else begin
          state_next = (idx_inc < total) ? S_RB_READ : S_RB_TAIL;
        end
      end
      S_RB_EMIT:  state_next = (idx_inc < total) ? S_RB_READ : S_RB_TAIL;
      S_RB_TAIL:  state_next = S_RB_FLUSH;
      S_RB_FLUSH: state_next = S_DONE;
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    act_next        = act;
    lo_next         = lo;
    hi_next         = hi;
    best_next       = best;
    touched_next    = touched;
    hit_next        = hit;
    have_next       = have;
    pend_next       = pend;
    placed_next     = placed;
    bvalid_next     = bvalid;
    bfirst_next     = bfirst;
    blast_next      = blast;
    idx_next        = idx;
    wk_next         = wk;
    total_next      = total;
    fin_status_next = fin_status;
    fin_found_next  = fin_found;
    raddr           = idx[IDX_W-1:0];
    mem_we          = 1'b0;
    waddr           = wk[IDX_W-1:0];
    wfirst          = bfirst;
    wlast           = blast;
    emit_en         = 1'b0;
    emit_first      = lo;
    emit_last       = hi;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          act_next        = req.action;
          lo_next         = req.uid_value;
          hi_next         = req.uid_value;
          touched_next    = 1'b0;
          hit_next        = 1'b0;
          have_next       = 1'b0;
          pend_next       = 1'b0;
          idx_next        = '0;
          fin_status_next = ST_OK;
          fin_found_next  = '0;
          if (req.action == ACT_ADD) begin
            hi_next = add_hi;
          end else if (req.action == ACT_NEXT_LOWER) begin
            lo_next = req.uid_value - {{(UID_W-1){1'b0}}, 1'b1};
            hi_next = req.uid_value - {{(UID_W-1){1'b0}}, 1'b1};
            if (req.uid_value == '0) fin_status_next = ST_BUSY;
          end
        end
      end
      S_SCAN: begin
        if (pend) begin
          if (act == ACT_ADD) begin
            if (cmp.touch) begin
              touched_next = 1'b1;
              if (cmp.first_lt_lo) lo_next = rfirst;
              if (cmp.last_gt_hi) hi_next = rlast;
            end
          end else begin
            if (cmp.lo_in_span) hit_next = 1'b1;
            if (cmp.below) begin
              best_next = rlast;
              have_next = 1'b1;
            end
          end
        end
        if (idx < total) begin
          pend_next = 1'b1;
          idx_next  = idx_inc;
        end else begin
          pend_next = 1'b0;
        end
      end
      S_CHECK: begin
        idx_next    = '0;
        wk_next     = '0;
        placed_next = 1'b0;
        bvalid_next = 1'b0;
        if (act == ACT_ADD) begin
          if (!touched && (total >= CNT_MAX)) fin_status_next = ST_FULL;
        end else if (act == ACT_CONTAINS) begin
          fin_status_next = hit ? ST_OK : ST_MISS;
        end else if (hit) begin
          fin_found_next = lo;
        end else if (have) begin
          fin_found_next = best;
        end else begin
          fin_status_next = ST_BUSY;
        end
      end
      S_RB_EVAL: begin
        if (cmp.covered) begin
          idx_next = idx_inc;
        end else if (!placed && cmp.after) begin
          emit_en     = 1'b1;
          placed_next = 1'b1;
        end else begin
          emit_en    = 1'b1;
          emit_first = rfirst;
          emit_last  = rlast;
          idx_next   = idx_inc;
        end
      end
      S_RB_EMIT: begin
        emit_en    = 1'b1;
        emit_first = rfirst;
        emit_last  = rlast;
        idx_next   = idx_inc;
      end
      S_RB_TAIL: begin
        if (!placed) begin
          emit_en     = 1'b1;
          placed_next = 1'b1;
        end
      end
      S_RB_FLUSH: begin
        if (bvalid) begin
          mem_we      = 1'b1;
          wk_next     = wk + CNT_ONE;
          bvalid_next = 1'b0;
          total_next  = wk + CNT_ONE;
        end else begin
          total_next  = wk;
        end
      end
      default: begin
      end
    endcase

    // one-deep write buffer keeps writes behind the read index
    if (emit_en) begin
      if (bvalid) begin
        mem_we  = 1'b1;
        wk_next = wk + CNT_ONE;
      end
      bfirst_next = emit_first;
      blast_next  = emit_last;
      bvalid_next = 1'b1;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      pend      <= 1'b0;
      bvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      total     <= total_next;
      pend      <= pend_next;
      bvalid    <= bvalid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    act        <= act_next;
    lo         <= lo_next;
    hi         <= hi_next;
    best       <= best_next;
    touched    <= touched_next;
    hit        <= hit_next;
    have       <= have_next;
    placed     <= placed_next;
    bfirst     <= bfirst_next;
    blast      <= blast_next;
    idx        <= idx_next;
    wk         <= wk_next;
    fin_status <= fin_status_next;
    fin_found  <= fin_found_next;
    if (out_load) begin
      out_status <= fin_status;
      out_found  <= fin_found;
      out_used   <= total_ext[USED_W-1:0];
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_MAX)
    else $error("interval count above table depth");

  a_write_in_rebuild: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_RB_EVAL || state == S_RB_EMIT ||
                state == S_RB_TAIL || state == S_RB_FLUSH))
    else $error("interval memory written outside rebuild");

  a_write_behind_read: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state == S_RB_EVAL || state == S_RB_EMIT)) |-> (wk <= idx))
    else $error("rebuild write overtook the read index");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("new transaction taken while one is in progress");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result presented outside the final step");
`endif

endmodule
